>>> hdl/spd_pkg.sv
// Shared types and constants for the serial packet deframer.
// No dependencies; imported by every module of the block but spd_ram.
package spd_pkg;

   localparam int MAX_PAYLOAD = 32;           // largest frame payload, 1..63
   localparam int LEN_W       = 6;            // width of length and index fields
   localparam int BYTE_W      = 8;

   // Frame descriptors in flight; one payload bank per slot (power of two).
   localparam int DESC_DEPTH  = 2;
   localparam int DPTR_W      = (DESC_DEPTH > 1) ? $clog2(DESC_DEPTH) : 1;
   localparam int DCNT_W      = $clog2(DESC_DEPTH + 1);

   // Payload RAM: bank number above the byte index within the frame.
   localparam int PIDX_AW     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int RAM_AW      = PIDX_AW + DPTR_W;
   localparam int RAM_DEPTH   = 2 ** RAM_AW;

   // Configuration registers
   localparam int CSR_AW      = 3;
   localparam logic [7:0] SYNC_RESET    = 8'd36;   // '$'
   localparam logic [7:0] TIMEOUT_RESET = 8'd10;

   typedef enum logic {
      REG_SYNC_BYTE     = 1'b0,
      REG_TIMEOUT_TICKS = 1'b1
   } csr_reg_type;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   // One accepted frame, handed from the front end to the output side.
   typedef struct packed {
      logic [BYTE_W-1:0] command;
      logic [LEN_W-1:0]  length;
      logic [DPTR_W-1:0] bank;
   } desc_type;

   // Payload RAM write request from the front end.
   typedef struct packed {
      logic              en;
      logic [RAM_AW-1:0] addr;
      logic [BYTE_W-1:0] data;
   } ram_wr_type;

endpackage

>>> hdl/serial_packet_deframer_top.sv
// Serial packet deframer: top level with configuration registers.
// Depends on spd_pkg, spd_front, spd_desc_fifo, spd_back and spd_ram.
//
// Usage
//  - req_* carries one item per transfer: a received serial byte
//    (req_tuser = 0, byte in req_tdata) or a timer tick (req_tuser = 1).
//    Frames are: sync byte, command, length, payload, 8-bit additive checksum.
//  - rsp_* returns each good frame as a start item (rsp_tuser = 1, command and
//    length, payload byte zero) followed by its payload bytes; rsp_tlast
//    marks the final item. Bad, oversized or timed-out frames give nothing.
//  - csr_* is an APB-style port: sync byte at 0x0, timeout ticks at 0x4.
//    Write only while the block is idle.
// Flow
//  - req_tready is high except when two good frames still wait to be played
//    out; otherwise one transfer per cycle is taken.
//  - rsp_tvalid rises once the checksum transfer has put the frame in the
//    queue and the output side is idle. Each payload item then goes through
//    the send, RAM read and load steps; the payload RAM read is registered.
// Reset
//  - Clears the hunt state, the idle timer (so the first byte always hunts),
//    the frame queue and rsp_tvalid; restores the register defaults.
//    The payload RAM is not cleared. A stalled result holds on rsp_* while
//    the front end keeps receiving into the other payload bank.
module serial_packet_deframer_top import spd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // input channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,    // [7:0] rx_byte
   input  logic              req_tuser,    // [0] operation
   // result channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,    // [7:0] frame_command, [13:8] frame_length,
                                           // [21:14] payload_byte, [23:22] zero
   output logic              rsp_tuser,    // [0] packet_start
   output logic              rsp_tlast,
   // configuration
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [BYTE_W-1:0] sync_ff, timeout_ff;
   logic              csr_wr;
   csr_reg_type       csr_sel;

   logic              push, pop, fifo_full, head_valid;
   desc_type          push_desc, head_desc;
   ram_wr_type        ram_wr;
   logic [RAM_AW-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;
   logic [BYTE_W-1:0] rsp_command, rsp_payload;
   logic [LEN_W-1:0]  rsp_length;

   // Register file: decode on the word address bit only.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = csr_reg_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff    <= SYNC_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr) begin
         unique case (csr_sel)
            REG_SYNC_BYTE:     sync_ff    <= csr_pwdata[BYTE_W-1:0];
            REG_TIMEOUT_TICKS: timeout_ff <= csr_pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_SYNC_BYTE:     csr_prdata = {24'd0, sync_ff};
         REG_TIMEOUT_TICKS: csr_prdata = {24'd0, timeout_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // Front end: classify bytes and ticks, store payload, check the sum.
   spd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_op         (req_tuser),
      .in_byte       (req_tdata),
      .sync_byte     (sync_ff),
      .timeout_ticks (timeout_ff),
      .fifo_full     (fifo_full),
      .push          (push),
      .push_desc     (push_desc),
      .ram_wr        (ram_wr)
   );

   // Payload banks, one per queue slot.
   spd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RAM_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Queue of good frames waiting to be played out.
   spd_desc_fifo u_desc_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .pop        (pop),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .full       (fifo_full)
   );

   // Output side: start item, then payload bytes from the frame's bank.
   spd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_desc   (head_desc),
      .pop         (pop),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_start   (rsp_tuser),
      .out_command (rsp_command),
      .out_length  (rsp_length),
      .out_payload (rsp_payload),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_payload, rsp_length, rsp_command};

endmodule

>>> hdl/spd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/spd_front.sv
// Front end: sync hunt, header capture, payload store and checksum check.
// Depends on spd_pkg; writes payload into spd_ram, pushes frames to spd_desc_fifo.
module spd_front import spd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              in_op,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic [BYTE_W-1:0] sync_byte,
   input  logic [BYTE_W-1:0] timeout_ticks,
   input  logic              fifo_full,
   output logic              push,
   output desc_type          push_desc,
   output ram_wr_type        ram_wr
);

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_CMD  = 3'd1,
      PH_LEN  = 3'd2,
      PH_DATA = 3'd3,
      PH_SUM  = 3'd4
   } phase_type;

   phase_type         phase_ff, phase_in, phase_eff;
   logic [BYTE_W-1:0] timer_ff, timer_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  idx_ff, idx_in, idx_inc;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [DPTR_W-1:0] bank_ff, bank_in;
   logic              accept;

   assign in_ready = !fifo_full;
   assign accept   = in_valid && in_ready;
   assign idx_inc  = idx_ff + 1'b1;

   assign push_desc.command = cmd_ff;
   assign push_desc.length  = len_ff;
   assign push_desc.bank    = bank_ff;

   always_comb begin
      phase_in    = phase_ff;
      timer_in    = timer_ff;
      cmd_in      = cmd_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      sum_in      = sum_ff;
      bank_in     = bank_ff;
      push        = 1'b0;
      ram_wr.en   = 1'b0;
      ram_wr.addr = {bank_ff, idx_ff[PIDX_AW-1:0]};
      ram_wr.data = in_byte;
      phase_eff   = (timer_ff == '0) ? PH_HUNT : phase_ff;

      if (accept && in_op == OP_TICK) begin
         // count down, hold at zero
         if (timer_ff != '0) begin
            timer_in = timer_ff - 1'b1;
         end
      end else if (accept) begin
         timer_in = timeout_ticks;
         unique case (phase_eff)
            PH_CMD: begin
               cmd_in   = in_byte;
               sum_in   = sum_ff + in_byte;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (in_byte > BYTE_W'(MAX_PAYLOAD)) begin
                  phase_in = PH_HUNT;   // drop oversized frame
               end else begin
                  len_in   = in_byte[LEN_W-1:0];
                  sum_in   = sum_ff + in_byte;
                  phase_in = (in_byte == '0) ? PH_SUM : PH_DATA;
               end
            end
            PH_DATA: begin
               ram_wr.en = 1'b1;
               sum_in    = sum_ff + in_byte;
               idx_in    = idx_inc;
               if (idx_inc >= len_ff) begin
                  phase_in = PH_SUM;
               end
            end
            PH_SUM: begin
               if (in_byte == sum_ff) begin
                  push    = 1'b1;
                  bank_in = bank_ff + 1'b1;
               end
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
               if (in_byte == sync_byte) begin
                  sum_in   = in_byte;
                  idx_in   = '0;
                  phase_in = PH_CMD;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         timer_ff <= '0;
         cmd_ff   <= '0;
         len_ff   <= '0;
         idx_ff   <= '0;
         sum_ff   <= '0;
         bank_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         idx_ff   <= idx_in;
         sum_ff   <= sum_in;
         bank_ff  <= bank_in;
      end
   end

endmodule

>>> hdl/spd_desc_fifo.sv
// Short queue of accepted frame descriptors between front end and output side.
// Depends on spd_pkg.
module spd_desc_fifo import spd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output logic     head_valid,
   output desc_type head_desc,
   output logic     full
);

   desc_type          entries_ff [DESC_DEPTH];
   logic [DPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [DCNT_W-1:0] count_ff;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == DCNT_W'(DESC_DEPTH));
   assign head_desc  = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> hdl/spd_back.sv
// Output side: plays one frame out as a start item and its payload bytes.
// Depends on spd_pkg; reads spd_ram and the head of spd_desc_fifo.
module spd_back import spd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  desc_type          head_desc,
   output logic              pop,
   output logic [RAM_AW-1:0] rd_addr,
   input  logic [BYTE_W-1:0] rd_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_start,
   output logic [BYTE_W-1:0] out_command,
   output logic [LEN_W-1:0]  out_length,
   output logic [BYTE_W-1:0] out_payload,
   output logic              out_last
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SEND  = 2'd1,
      ST_FETCH = 2'd2,
      ST_LOAD  = 2'd3
   } state_type;

   state_type         state_ff;
   logic [LEN_W-1:0]  idx_ff;
   logic [LEN_W-1:0]  idx_inc;
   logic              valid_ff, start_ff, last_ff;
   logic [BYTE_W-1:0] cmd_ff, payload_ff;
   logic [LEN_W-1:0]  len_ff;
   logic              sent;

   assign idx_inc = idx_ff + 1'b1;
   assign sent    = (state_ff == ST_SEND) && out_ready;
   assign pop     = sent && last_ff;
   assign rd_addr = {head_desc.bank, idx_ff[PIDX_AW-1:0]};

   assign out_valid   = valid_ff;
   assign out_start   = start_ff;
   assign out_command = cmd_ff;
   assign out_length  = len_ff;
   assign out_payload = payload_ff;
   assign out_last    = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= 1'b0;
         idx_ff     <= '0;
         start_ff   <= 1'b0;
         last_ff    <= 1'b0;
         cmd_ff     <= '0;
         len_ff     <= '0;
         payload_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (head_valid) begin
                  valid_ff   <= 1'b1;
                  start_ff   <= 1'b1;
                  cmd_ff     <= head_desc.command;
                  len_ff     <= head_desc.length;
                  payload_ff <= '0;
                  last_ff    <= (head_desc.length == '0);
                  idx_ff     <= '0;
                  state_ff   <= ST_SEND;
               end
            end
            ST_SEND: begin
               if (out_ready) begin
                  valid_ff <= 1'b0;
                  if (last_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     if (!start_ff) begin
                        idx_ff <= idx_inc;
                     end
                     state_ff <= ST_FETCH;
                  end
               end
            end
            ST_FETCH: begin
               state_ff <= ST_LOAD;   // RAM registers the byte at this edge
            end
            ST_LOAD: begin
               valid_ff   <= 1'b1;
               start_ff   <= 1'b0;
               payload_ff <= rd_data;
               last_ff    <= (idx_inc == len_ff);
               state_ff   <= ST_SEND;
            end
            default: begin
               state_ff <= ST_IDLE;
               valid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

>>> hdl/spd_checker.sv
// Port-level checks for the serial packet deframer, bound to the top level.
// Depends on spd_pkg and serial_packet_deframer_top.
module spd_checker import spd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [7:0]        req_tdata,
   input logic              req_tuser,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [23:0]       rsp_tdata,
   input logic              rsp_tuser,
   input logic              rsp_tlast,
   input logic              csr_psel,
   input logic              csr_penable,
   input logic              csr_pwrite,
   input logic [CSR_AW-1:0] csr_paddr,
   input logic [31:0]       csr_pwdata,
   input logic [31:0]       csr_prdata,
   input logic              csr_pready
);

   // No result may be offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // A start item with no payload closes its run and carries a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[21:14] == 8'd0
         && (rsp_tdata[13:8] != 6'd0 || rsp_tlast))
      else $error("bad start item");

   // Lengths above the payload limit never reach the output.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[13:8] <= LEN_W'(MAX_PAYLOAD))
      else $error("oversized frame played out");

endmodule

bind serial_packet_deframer_top spd_checker u_checker (.*);
